// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while in reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication, ignored while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, ignored while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/ccm_pkg.sv
// ---------------------------------------------------------------------------
// ccm_pkg
// Types and constants of the colour correction matrix block.
// ---------------------------------------------------------------------------
package ccm_pkg;

	localparam int PIX_W              = 8;
	localparam int PIX_MAX            = 255;
	localparam int COEFF_W            = 16;
	localparam int ROW_W              = 3 * COEFF_W;
	localparam int OFFS_W             = 18;
	localparam int OFFS_ALL_W         = 3 * OFFS_W;
	localparam int OFFS_FRAC_BITS     = 8;
	localparam int COEFF_FRAC_DEF     = 12;
	localparam int COEFF_FRAC_MAX     = 14;
	localparam int PROD_W             = COEFF_W + PIX_W + 1;
	localparam int ACC_W              = 28;
	// clamped raw channel value, 0 .. 255 * 2^F
	localparam int RAW_W              = PIX_W + COEFF_FRAC_MAX;
	localparam int SUM_W              = RAW_W + 2;
	// rounded sum over 2^(F+1), at most 766
	localparam int Q_W                = 10;
	// x / 3 as (x * 683) >> 11, exact for x below 1024
	localparam int DIV3_MUL           = 683;
	localparam int DIV3_SHIFT         = 11;
	localparam int DIV3_MUL_W         = 11;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 54;
	localparam int NSTG               = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_RED   = 3'd0,
		REG_ROW_GREEN = 3'd1,
		REG_ROW_BLUE  = 3'd2,
		REG_OFFSETS   = 3'd3,
		REG_GRAY_MODE = 3'd4
	} cfg_reg_t;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_ctl_t;

endpackage

// File: rtl/ccm_pix_in_if.sv
// ---------------------------------------------------------------------------
// ccm_pix_in_if
// Input pixel channel: valid/ready with one RGB word.
// ---------------------------------------------------------------------------
interface ccm_pix_in_if;
	import ccm_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] in_r;
	logic [PIX_W-1:0] in_g;
	logic [PIX_W-1:0] in_b;

	modport source (output valid, output in_r, output in_g, output in_b, input ready);
	modport sink   (input valid, input in_r, input in_g, input in_b, output ready);
endinterface

// File: rtl/ccm_pix_out_if.sv
// ---------------------------------------------------------------------------
// ccm_pix_out_if
// Output pixel channel: valid/ready with one corrected RGB word.
// ---------------------------------------------------------------------------
interface ccm_pix_out_if;
	import ccm_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_r;
	logic [PIX_W-1:0] out_g;
	logic [PIX_W-1:0] out_b;

	modport source (output valid, output out_r, output out_g, output out_b, input ready);
	modport sink   (input valid, input out_r, input out_g, input out_b, output ready);
endinterface

// File: rtl/ccm_cfg_if.sv
// ---------------------------------------------------------------------------
// ccm_cfg_if
// Register write channel: valid/ready with index and data.
// ---------------------------------------------------------------------------
interface ccm_cfg_if;
	import ccm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ccm_lane.sv
// ---------------------------------------------------------------------------
// ccm_lane
// One output channel: row dot product plus offset, then round/saturate and
// raw clamp.
// ---------------------------------------------------------------------------
module ccm_lane #(
	parameter int COEFF_FRAC_BITS = ccm_pkg::COEFF_FRAC_DEF
) (
	input  logic                            clk,
	input  ccm_pkg::pipe_ctl_t              ctl,
	input  logic                            gray,
	input  logic [ccm_pkg::PIX_W-1:0]       pix_r,
	input  logic [ccm_pkg::PIX_W-1:0]       pix_g,
	input  logic [ccm_pkg::PIX_W-1:0]       pix_b,
	input  logic [ccm_pkg::ROW_W-1:0]       row,
	input  logic [ccm_pkg::OFFS_W-1:0]      offset,
	output logic [ccm_pkg::PIX_W-1:0]       sat_s3,
	output logic [ccm_pkg::RAW_W-1:0]       raw_s3
);
	import ccm_pkg::*;

	localparam logic signed [ACC_W:0] HALF =
		(ACC_W + 1)'(1) << (COEFF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] RAW_TOP =
		ACC_W'(PIX_MAX) << COEFF_FRAC_BITS;

	logic [PIX_W-1:0]         p1, p2;
	logic signed [PROD_W-1:0] prod0_s1, prod1_s1, prod2_s1;
	logic signed [ACC_W-1:0]  offs_s1;
	logic signed [ACC_W-1:0]  acc_s2;
	logic signed [ACC_W:0]    rnd;
	logic signed [ACC_W:0]    shr;
	logic [PIX_W-1:0]         sat_d;
	logic [RAW_W-1:0]         raw_d;

	// gray value drives all three coefficient columns
	assign p1 = gray ? pix_r : pix_g;
	assign p2 = gray ? pix_r : pix_b;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod0_s1 <= $signed(row[COEFF_W-1:0]) * $signed({1'b0, pix_r});
			prod1_s1 <= $signed(row[2*COEFF_W-1:COEFF_W]) * $signed({1'b0, p1});
			prod2_s1 <= $signed(row[3*COEFF_W-1:2*COEFF_W]) * $signed({1'b0, p2});
			offs_s1  <= $signed({{(ACC_W - OFFS_W){offset[OFFS_W-1]}}, offset})
				<<< (COEFF_FRAC_BITS - OFFS_FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			acc_s2 <= ACC_W'(prod0_s1) + ACC_W'(prod1_s1) + ACC_W'(prod2_s1) + offs_s1;
		end
	end

	always_comb begin
		rnd = {acc_s2[ACC_W-1], acc_s2} + HALF;
		shr = rnd >>> COEFF_FRAC_BITS;
		if (rnd[ACC_W])
			sat_d = '0;
		else if (shr > (ACC_W + 1)'(PIX_MAX))
			sat_d = PIX_W'(PIX_MAX);
		else
			sat_d = shr[PIX_W-1:0];

		if (acc_s2[ACC_W-1])
			raw_d = '0;
		else if (acc_s2 > RAW_TOP)
			raw_d = RAW_TOP[RAW_W-1:0];
		else
			raw_d = acc_s2[RAW_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			sat_s3 <= sat_d;
			raw_s3 <= raw_d;
		end
	end
endmodule

// File: rtl/ccm_merge.sv
// ---------------------------------------------------------------------------
// ccm_merge
// Combines the three lanes: passes colour results or forms the gray average.
// ---------------------------------------------------------------------------
module ccm_merge #(
	parameter int COEFF_FRAC_BITS = ccm_pkg::COEFF_FRAC_DEF
) (
	input  logic                      clk,
	input  ccm_pkg::pipe_ctl_t        ctl,
	input  logic                      gray,
	input  logic [ccm_pkg::PIX_W-1:0] sat_r,
	input  logic [ccm_pkg::PIX_W-1:0] sat_g,
	input  logic [ccm_pkg::PIX_W-1:0] sat_b,
	input  logic [ccm_pkg::RAW_W-1:0] raw_r,
	input  logic [ccm_pkg::RAW_W-1:0] raw_g,
	input  logic [ccm_pkg::RAW_W-1:0] raw_b,
	output logic [ccm_pkg::PIX_W-1:0] out_r_s5,
	output logic [ccm_pkg::PIX_W-1:0] out_g_s5,
	output logic [ccm_pkg::PIX_W-1:0] out_b_s5
);
	import ccm_pkg::*;

	localparam int NUM_W = SUM_W + 1;
	localparam logic [NUM_W-1:0] THREE_HALF_UNIT = NUM_W'(3) << COEFF_FRAC_BITS;
	localparam int QM_W = Q_W + DIV3_MUL_W;

	logic [SUM_W-1:0] sum;
	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] num_shr;
	logic [Q_W-1:0]   q_s4;
	logic [PIX_W-1:0] sat_r_s4, sat_g_s4, sat_b_s4;
	logic [QM_W-1:0]  qm;
	logic [QM_W-1:0]  avg;
	logic [PIX_W-1:0] avg_sat;

	// (2S + 3U) / (6U) = ((2S + 3U) >> (F+1)) / 3
	always_comb begin
		sum     = SUM_W'(raw_r) + SUM_W'(raw_g) + SUM_W'(raw_b);
		num     = {sum, 1'b0} + THREE_HALF_UNIT;
		num_shr = num >> (COEFF_FRAC_BITS + 1);
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			q_s4     <= num_shr[Q_W-1:0];
			sat_r_s4 <= sat_r;
			sat_g_s4 <= sat_g;
			sat_b_s4 <= sat_b;
		end
	end

	always_comb begin
		qm  = QM_W'(q_s4) * QM_W'(DIV3_MUL);
		avg = qm >> DIV3_SHIFT;
		if (avg > QM_W'(PIX_MAX))
			avg_sat = PIX_W'(PIX_MAX);
		else
			avg_sat = avg[PIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			if (gray) begin
				out_r_s5 <= avg_sat;
				out_g_s5 <= '0;
				out_b_s5 <= '0;
			end else begin
				out_r_s5 <= sat_r_s4;
				out_g_s5 <= sat_g_s4;
				out_b_s5 <= sat_b_s4;
			end
		end
	end
endmodule

// File: rtl/color_correction_matrix_apply.sv
// ---------------------------------------------------------------------------
// color_correction_matrix_apply
// 3x3 colour correction with per-channel offset, rounding and saturation,
// plus a gray averaging mode.
// ---------------------------------------------------------------------------
//  channel   dir  word                         accepted when
//  pix_in    in   in_r, in_g, in_b             valid && ready
//  pix_out   out  out_r, out_g, out_b          valid && ready
//  cfg       in   index, data (register write) valid && ready (ready is 1)
//
//  One pixel per clock while pix_out.ready holds high; five pipeline registers (products,
//  accumulate, round/clamp, gray sum, output) carry each accepted word to pix_out.
//  Three lanes, one per output channel, each with three 16x9 multipliers.
//  Each stage loads when empty or when the next one moves, so bubbles close
//  up under an output stall; pix_in.ready falls only when all stages are full.
//  Reset restores identity coefficients, zero offsets and colour mode.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module color_correction_matrix_apply #(
	parameter int COEFF_FRAC_BITS = ccm_pkg::COEFF_FRAC_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	ccm_pix_in_if.sink    pix_in,
	ccm_pix_out_if.source pix_out,
	ccm_cfg_if.sink       cfg
);
	import ccm_pkg::*;

	localparam logic [ROW_W-1:0] ONE_R = ROW_W'(1) << COEFF_FRAC_BITS;
	localparam logic [ROW_W-1:0] ONE_G = ROW_W'(1) << (COEFF_W + COEFF_FRAC_BITS);
	localparam logic [ROW_W-1:0] ONE_B = ROW_W'(1) << (2 * COEFF_W + COEFF_FRAC_BITS);

	logic [ROW_W-1:0]      row_r_q, row_g_q, row_b_q;
	logic [OFFS_ALL_W-1:0] offs_q;
	logic                  gray_q;
	logic [NSTG-1:0]       v_q;
	logic [NSTG-1:0]       adv;
	pipe_ctl_t             ctl;
	logic [PIX_W-1:0]      sat_r, sat_g, sat_b;
	logic [RAW_W-1:0]      raw_r, raw_g, raw_b;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_r_q <= ONE_R;
			row_g_q <= ONE_G;
			row_b_q <= ONE_B;
			offs_q  <= '0;
			gray_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ROW_RED:   row_r_q <= cfg.data[ROW_W-1:0];
				REG_ROW_GREEN: row_g_q <= cfg.data[ROW_W-1:0];
				REG_ROW_BLUE:  row_b_q <= cfg.data[ROW_W-1:0];
				REG_OFFSETS:   offs_q  <= cfg.data[OFFS_ALL_W-1:0];
				REG_GRAY_MODE: gray_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// pipeline occupancy; a stage moves if empty or its successor moves
	always_comb begin
		adv[NSTG-1] = !v_q[NSTG-1] || pix_out.ready;
		for (int k = NSTG - 2; k >= 0; k--)
			adv[k] = !v_q[k] || adv[k+1];
	end

	assign ctl.en_s1 = adv[0];
	assign ctl.en_s2 = adv[1];
	assign ctl.en_s3 = adv[2];
	assign ctl.en_s4 = adv[3];
	assign ctl.en_s5 = adv[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= pix_in.valid;
			for (int k = 1; k < NSTG; k++)
				if (adv[k])
					v_q[k] <= v_q[k-1];
		end
	end

	assign pix_in.ready  = adv[0];
	assign pix_out.valid = v_q[NSTG-1];

	ccm_lane #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_r (
		.clk    (clk),
		.ctl    (ctl),
		.gray   (gray_q),
		.pix_r  (pix_in.in_r),
		.pix_g  (pix_in.in_g),
		.pix_b  (pix_in.in_b),
		.row    (row_r_q),
		.offset (offs_q[OFFS_W-1:0]),
		.sat_s3 (sat_r),
		.raw_s3 (raw_r)
	);

	ccm_lane #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_g (
		.clk    (clk),
		.ctl    (ctl),
		.gray   (gray_q),
		.pix_r  (pix_in.in_r),
		.pix_g  (pix_in.in_g),
		.pix_b  (pix_in.in_b),
		.row    (row_g_q),
		.offset (offs_q[2*OFFS_W-1:OFFS_W]),
		.sat_s3 (sat_g),
		.raw_s3 (raw_g)
	);

	ccm_lane #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_b (
		.clk    (clk),
		.ctl    (ctl),
		.gray   (gray_q),
		.pix_r  (pix_in.in_r),
		.pix_g  (pix_in.in_g),
		.pix_b  (pix_in.in_b),
		.row    (row_b_q),
		.offset (offs_q[3*OFFS_W-1:2*OFFS_W]),
		.sat_s3 (sat_b),
		.raw_s3 (raw_b)
	);

	ccm_merge #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_merge (
		.clk      (clk),
		.ctl      (ctl),
		.gray     (gray_q),
		.sat_r    (sat_r),
		.sat_g    (sat_g),
		.sat_b    (sat_b),
		.raw_r    (raw_r),
		.raw_g    (raw_g),
		.raw_b    (raw_b),
		.out_r_s5 (pix_out.out_r),
		.out_g_s5 (pix_out.out_g),
		.out_b_s5 (pix_out.out_b)
	);

	// an accepted word is always in the first stage next cycle
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, pix_in.valid && pix_in.ready, v_q[0])
	// input is refused only when every stage is full and the output stalls
	`ASSERT_IMPLIES(a_ready_when_room, clk, arst_n, !pix_in.ready, (&v_q) && !pix_out.ready)
	// gray results carry zero on the green and blue fields
	`ASSERT_IMPLIES(a_gray_zero_gb, clk, arst_n, pix_out.valid && gray_q,
		pix_out.out_g == '0 && pix_out.out_b == '0)
endmodule
